[hdl/olte_pkg.sv]
// Shared types, codes and widths for the ordered list table engine.
package olte_pkg;

   localparam int DEFAULT_CAPACITY = 1024;

   localparam int VALUE_W  = 64;
   localparam int POS_W    = 10;
   localparam int LEN_W    = 11;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_READ   = 3'd1,
      CMD_REMOVE = 3'd2,
      CMD_FIND   = 3'd3,
      CMD_FILL   = 3'd4,
      CMD_MAX    = 3'd5,
      CMD_MIN    = 3'd6,
      CMD_CLEAR  = 3'd7
   } olte_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_RANGE = 3'd1,
      ST_FULL  = 3'd2,
      ST_EMPTY = 3'd3,
      ST_ORDER = 3'd4
   } olte_status_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_PASS = 1'b1
   } olte_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic [POS_W-1:0]   found_index;
      logic               found;
      olte_status_type    status;
      logic [LEN_W-1:0]   length;
   } olte_rsp_type;

endpackage

[hdl/olte_ifs.sv]
// Valid/ready channel interfaces for commands and results.
interface olte_req_if import olte_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [VALUE_W-1:0]  value;
   logic [POS_W-1:0]    first_pos;
   logic [POS_W-1:0]    last_pos;

   modport source (output valid, command, value, first_pos, last_pos,
                   input ready);
   modport sink   (input valid, command, value, first_pos, last_pos,
                   output ready);
endinterface

interface olte_rsp_if import olte_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  read_value;
   logic [POS_W-1:0]    found_index;
   logic                found;
   logic [STATUS_W-1:0] status;
   logic [LEN_W-1:0]    length;

   modport source (output valid, read_value, found_index, found, status, length,
                   input ready);
   modport sink   (input valid, read_value, found_index, found, status, length,
                   output ready);
endinterface

[hdl/olte_cell.sv]
// One storage cell of the rotating word ring.
module olte_cell import olte_pkg::*; (
   input  logic               clock,
   input  logic               shift_en,
   input  logic [VALUE_W-1:0] data_in,
   output logic [VALUE_W-1:0] data_out
);

   logic [VALUE_W-1:0] word_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         word_ff <= data_in;
      end
   end

   assign data_out = word_ff;

endmodule

[hdl/olte_seq.sv]
// Command sequencer and ring head unit: checks, pass control, result register.
module olte_seq import olte_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   olte_req_if.sink           req_bus,
   olte_rsp_if.source         rsp_bus,
   output logic               shift_en,
   output logic [VALUE_W-1:0] feed_word,
   input  logic [VALUE_W-1:0] head_word,
   input  logic [VALUE_W-1:0] next_word
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [IDX_W-1:0] LAST_K = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   olte_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   olte_cmd_type       cmd_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [CMP_W-1:0]   sp_ff, ep_ff;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   olte_rsp_type       rsp_ff, rsp_in;

   olte_cmd_type       req_cmd;
   logic [CMP_W-1:0]   req_sp, req_ep, cnt_ext, k_ext;
   logic               rsp_free, accept, go_pass, pass_last;
   logic               in_list, at_or_after;
   olte_status_type    imm_status;

   assign req_cmd  = olte_cmd_type'(req_bus.command);
   assign req_sp   = CMP_W'(req_bus.first_pos);
   assign req_ep   = CMP_W'(req_bus.last_pos);
   assign cnt_ext  = CMP_W'(cnt_ff);
   assign k_ext    = CMP_W'(k_ff);
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign accept   = req_bus.valid && req_bus.ready;

   // Up-front checks: errors and clear answer at once, the rest take a pass.
   always_comb begin
      imm_status = ST_OK;
      go_pass    = 1'b1;
      case (req_cmd)
         CMD_APPEND: begin
            if (cnt_ff == FULL_CNT) begin
               imm_status = ST_FULL;
               go_pass    = 1'b0;
            end
         end
         CMD_READ, CMD_REMOVE, CMD_FIND: begin
            if (req_sp >= cnt_ext) begin
               imm_status = ST_RANGE;
               go_pass    = 1'b0;
            end
         end
         CMD_FILL: begin
            if (req_sp >= cnt_ext) begin
               imm_status = ST_RANGE;
               go_pass    = 1'b0;
            end else if (req_sp > req_ep) begin
               imm_status = ST_ORDER;
               go_pass    = 1'b0;
            end else if (req_ep >= cnt_ext) begin
               imm_status = ST_RANGE;
               go_pass    = 1'b0;
            end
         end
         CMD_MAX, CMD_MIN: begin
            if (cnt_ff == '0) begin
               imm_status = ST_EMPTY;
               go_pass    = 1'b0;
            end
         end
         default: begin
            go_pass = 1'b0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept && go_pass) begin
               state_in = SEQ_PASS;
            end
         end
         SEQ_PASS: begin
            if (k_ff == LAST_K) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_bus.ready = (state_ff == SEQ_IDLE) && rsp_free;
      shift_en      = (state_ff == SEQ_PASS);
      pass_last     = (state_ff == SEQ_PASS) && (k_ff == LAST_K);
   end

   assign k_in = (state_ff == SEQ_PASS) ? (pass_last ? '0 : k_ff + 1'b1) : '0;

   // Head unit: sees position k at the ring head, position k+1 behind it.
   always_comb begin
      in_list     = k_ext < cnt_ext;
      at_or_after = k_ext >= sp_ff;
      feed_word   = head_word;
      acc_in      = acc_ff;
      found_in    = found_ff;
      idx_in      = idx_ff;
      case (cmd_ff)
         CMD_APPEND: begin
            if (k_ext == cnt_ext) begin
               feed_word = val_ff;
            end
         end
         CMD_READ: begin
            if (k_ext == sp_ff) begin
               acc_in = head_word;
            end
         end
         CMD_REMOVE: begin
            if (at_or_after) begin
               feed_word = next_word;
            end
         end
         CMD_FIND: begin
            if (!found_ff && at_or_after && in_list && (head_word == val_ff)) begin
               found_in = 1'b1;
               idx_in   = k_ff;
            end
         end
         CMD_FILL: begin
            if (at_or_after && (k_ext <= ep_ff)) begin
               feed_word = val_ff;
            end
         end
         CMD_MAX: begin
            if ((k_ff == '0) || (in_list && (head_word > acc_ff))) begin
               acc_in = head_word;
            end
         end
         CMD_MIN: begin
            if ((k_ff == '0) || (in_list && (head_word < acc_ff))) begin
               acc_in = head_word;
            end
         end
         default: begin
         end
      endcase
   end

   // Length bookkeeping
   always_comb begin
      cnt_in = cnt_ff;
      if (accept && (req_cmd == CMD_CLEAR)) begin
         cnt_in = '0;
      end else if (pass_last && (cmd_ff == CMD_APPEND)) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pass_last && (cmd_ff == CMD_REMOVE)) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_in       = rsp_ff;
      if (accept && !go_pass) begin
         rsp_valid_in       = 1'b1;
         rsp_in.read_value  = '0;
         rsp_in.found_index = '0;
         rsp_in.found       = 1'b0;
         rsp_in.status      = imm_status;
         rsp_in.length      = LEN_W'(cnt_in);
      end else if (pass_last) begin
         rsp_valid_in       = 1'b1;
         rsp_in.read_value  = ((cmd_ff == CMD_READ) || (cmd_ff == CMD_MAX) ||
                               (cmd_ff == CMD_MIN)) ? acc_in : '0;
         rsp_in.found       = (cmd_ff == CMD_FIND) && found_in;
         rsp_in.found_index = ((cmd_ff == CMD_FIND) && found_in) ? POS_W'(idx_in) : '0;
         rsp_in.status      = ST_OK;
         rsp_in.length      = LEN_W'(cnt_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         k_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         val_ff   <= req_bus.value;
         sp_ff    <= req_sp;
         ep_ff    <= req_ep;
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      acc_ff <= acc_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.read_value  = rsp_ff.read_value;
   assign rsp_bus.found_index = rsp_ff.found_index;
   assign rsp_bus.found       = rsp_ff.found;
   assign rsp_bus.status      = rsp_ff.status;
   assign rsp_bus.length      = rsp_ff.length;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("entry count above capacity");

   a_pass_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_PASS) && (k_ff == LAST_K) |=> (state_ff == SEQ_IDLE) && rsp_valid_ff)
      else $error("pass did not end with a result");

   a_no_pending_in_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_PASS) |-> !rsp_valid_ff)
      else $error("result pending while a pass runs");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> (rsp_ff.status == ST_OK))
      else $error("match reported with an error status");
`endif

endmodule

[hdl/ordered_list_table_engine_core.sv]
// Top level of the ordered list table engine: a rotating ring of word cells.
//
// Holds a list of up to CAPACITY 64-bit words in a ring of CAPACITY cells.
// Every command that touches the stored words (append, read, remove, find,
// fill, max, min) takes one full rotation of the ring: the words march past
// the head unit one per cycle, in position order, and are fed back at the
// tail, rewritten where the command says so. Clear and every command that
// fails its range, order, capacity or empty check answers in the cycle
// after acceptance, with no rotation. One command is in service at a time;
// the command channel accepts a new transaction when the engine is idle and
// the result register is free or being drained in the same cycle. Results
// come out in command order, one per command, and always carry the list
// length after the command.
module ordered_list_table_engine_core import olte_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   olte_req_if.sink    req_bus,
   olte_rsp_if.source  rsp_bus
);

   logic               shift_en;
   logic [VALUE_W-1:0] feed_word;
   logic [VALUE_W-1:0] ring_q [CAPACITY];

   // Sequencer: checks commands, runs the rotation, owns the result register.
   olte_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .shift_en  (shift_en),
      .feed_word (feed_word),
      .head_word (ring_q[0]),
      .next_word (ring_q[1])
   );

   // Ring: each cell takes its neighbor's word; the last takes the feed word.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_ring
      if (i == CAPACITY - 1) begin : g_tail
         olte_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .data_in  (feed_word),
            .data_out (ring_q[i])
         );
      end else begin : g_body
         olte_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .data_in  (ring_q[i+1]),
            .data_out (ring_q[i])
         );
      end
   end

endmodule
